@@ rtl/accumulator_alu_with_flags_unit_defines.svh @@
// Assertion macros shared by the RTL files.
// AFU_ASSERT checks a property at every rising edge outside reset.
// AFU_ASSERT_ALWAYS checks a property at every rising edge, reset included.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define AFU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define AFU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define AFU_ASSERT(lbl, clk, rst_n, prop)
`define AFU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/aluf_pkg.sv @@
`default_nettype none

package aluf_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned DATA_W = 8;

    localparam logic [DATA_W-1:0] ACC_RESET = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_CP   = 5'd4,
        CMD_AND  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_XOR  = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_RLCA = 5'd10,
        CMD_RRCA = 5'd11,
        CMD_RLA  = 5'd12,
        CMD_RRA  = 5'd13,
        CMD_CPL  = 5'd14,
        CMD_SCF  = 5'd15,
        CMD_CCF  = 5'd16
    } t_cmd;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] operand_value;
    } t_req_item;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        t_flags            flags;
        logic              write_acc;
    } t_exec_res;

endpackage

`default_nettype wire

@@ rtl/aluf_req_if.sv @@
`default_nettype none

interface aluf_req_if;
    logic                            valid;
    logic                            ready;
    logic [aluf_pkg::CMD_W-1:0]      command;
    logic [aluf_pkg::DATA_W-1:0]     operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

`default_nettype wire

@@ rtl/aluf_rsp_if.sv @@
`default_nettype none

interface aluf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [aluf_pkg::DATA_W-1:0]     result_value;
    logic [aluf_pkg::DATA_W-1:0]     flags_out;

    modport source (output valid, output result_value, output flags_out, input ready);
    modport sink   (input valid, input result_value, input flags_out, output ready);
endinterface

`default_nettype wire

@@ rtl/aluf_in_reg.sv @@
`default_nettype none

// Request register: takes a new request whenever empty or draining this cycle.
module aluf_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    aluf_req_if.sink           i_req,
    input  wire logic          i_advance,
    output logic               o_valid,
    output aluf_pkg::t_req_item o_item
);

    logic                r_valid;
    aluf_pkg::t_req_item r_item;
    logic                n_valid;
    logic                w_take;

    assign i_req.ready = !r_valid || i_advance;
    assign w_take      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.command       <= i_req.command;
            r_item.operand_value <= i_req.operand_value;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/aluf_exec.sv @@
`default_nettype none

// One ALU operation against the current accumulator and flags.
module aluf_exec (
    input  wire aluf_pkg::t_req_item      i_item,
    input  wire logic [aluf_pkg::DATA_W-1:0] i_acc,
    input  wire aluf_pkg::t_flags         i_flags,
    output aluf_pkg::t_exec_res           o_res
);

    logic [aluf_pkg::DATA_W-1:0] a;
    logic [aluf_pkg::DATA_W-1:0] v;
    logic                        cin_add;
    logic                        cin_sub;
    logic [aluf_pkg::DATA_W:0]   sum9;
    logic [4:0]                  sum_lo;
    logic [aluf_pkg::DATA_W:0]   dif9;
    logic [4:0]                  dif_lo;
    logic [aluf_pkg::DATA_W-1:0] r;
    aluf_pkg::t_flags            nf;
    logic                        wr;

    assign a = i_acc;
    assign v = i_item.operand_value;

    assign cin_add = (i_item.command == aluf_pkg::CMD_ADC) ? i_flags.c : 1'b0;
    assign cin_sub = (i_item.command == aluf_pkg::CMD_SBC) ? i_flags.c : 1'b0;

    assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin_add};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin_add};
    // bit 8 / bit 4 of the difference is the borrow
    assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, cin_sub};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin_sub};

    always_comb begin
        r  = a;
        nf = i_flags;
        wr = 1'b1;
        case (aluf_pkg::t_cmd'(i_item.command))
            aluf_pkg::CMD_ADD, aluf_pkg::CMD_ADC: begin
                r  = sum9[7:0];
                nf = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
            end
            aluf_pkg::CMD_SUB, aluf_pkg::CMD_SBC: begin
                r  = dif9[7:0];
                nf = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif_lo[4], c: dif9[8]};
            end
            aluf_pkg::CMD_CP: begin
                nf = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif_lo[4], c: dif9[8]};
                wr = 1'b0;
            end
            aluf_pkg::CMD_AND: begin
                r  = a & v;
                nf = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            aluf_pkg::CMD_OR: begin
                r  = a | v;
                nf = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            aluf_pkg::CMD_XOR: begin
                r  = a ^ v;
                nf = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            aluf_pkg::CMD_INC: begin
                r  = v + 8'd1;
                nf = '{z: (v == 8'hFF), n: 1'b0, h: (v[3:0] == 4'hF), c: i_flags.c};
                wr = 1'b0;
            end
            aluf_pkg::CMD_DEC: begin
                r  = v - 8'd1;
                nf = '{z: (v == 8'h01), n: 1'b1, h: (v[3:0] == 4'h0), c: i_flags.c};
                wr = 1'b0;
            end
            aluf_pkg::CMD_RLCA: begin
                r  = {a[6:0], a[7]};
                nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            aluf_pkg::CMD_RRCA: begin
                r  = {a[0], a[7:1]};
                nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            aluf_pkg::CMD_RLA: begin
                r  = {a[6:0], i_flags.c};
                nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            aluf_pkg::CMD_RRA: begin
                r  = {i_flags.c, a[7:1]};
                nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            aluf_pkg::CMD_CPL: begin
                r  = ~a;
                nf = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            aluf_pkg::CMD_SCF: begin
                nf = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            aluf_pkg::CMD_CCF: begin
                nf = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: !i_flags.c};
            end
            default: begin
                // unknown code: hold everything
                wr = 1'b0;
            end
        endcase
    end

    assign o_res.result_value = r;
    assign o_res.flags        = nf;
    assign o_res.write_acc    = wr;

endmodule

`default_nettype wire

@@ rtl/aluf_out_reg.sv @@
`default_nettype none

// Response register: loads when empty or when the consumer takes the held response.
module aluf_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire aluf_pkg::t_exec_res  i_res,
    output logic                      o_can_load,
    aluf_rsp_if.source                o_rsp
);

    logic                        r_valid;
    logic [aluf_pkg::DATA_W-1:0] r_result;
    aluf_pkg::t_flags            r_flags;
    logic                        n_valid;

    assign o_can_load = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_res.result_value;
            r_flags  <= i_res.flags;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.result_value = r_result;
    assign o_rsp.flags_out    = {r_flags, 4'b0000};

endmodule

`default_nettype wire

@@ rtl/accumulator_alu_with_flags_unit.sv @@
`default_nettype none
`include "accumulator_alu_with_flags_unit_defines.svh"

// 8-bit accumulator ALU with Z, N, H and C flags. Each request carries a command
// (ADD, ADC, SUB, SBC, CP, AND, OR, XOR, INC, DEC, RLCA, RRCA, RLA, RRA, CPL, SCF,
// CCF) and an operand; each produces exactly one response with the result byte
// and the new flag byte (Z bit 7, N bit 6, H bit 5, C bit 4, low nibble zero).
// Requests are taken one per clock unless the response side stalls; an accepted
// request passes through the request register, then the response register. The
// rate is set by the accumulator/flag feedback loop, which closes through the
// execute logic. After reset the accumulator holds 0x01 and all flags are clear.
// Unknown commands change nothing and return the accumulator and the current
// flags. Either side may stall at any time; nothing is dropped.
module accumulator_alu_with_flags_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aluf_req_if.sink   i_req,
    aluf_rsp_if.source o_rsp
);

    logic                        w_in_valid;
    aluf_pkg::t_req_item         w_item;
    aluf_pkg::t_exec_res         w_res;
    logic                        w_can_load;
    logic                        w_fire;

    logic [aluf_pkg::DATA_W-1:0] r_acc;
    aluf_pkg::t_flags            r_flags;

    // Hold the request until the response register can take its result.
    aluf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_can_load),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    aluf_exec u_exec (
        .i_item  (w_item),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_res   (w_res)
    );

    // Execute a request exactly once: when it moves into the response register.
    assign w_fire = w_in_valid && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= aluf_pkg::ACC_RESET;
            r_flags <= '0;
        end else if (w_fire) begin
            if (w_res.write_acc) begin
                r_acc <= w_res.result_value;
            end
            r_flags <= w_res.flags;
        end
    end

    aluf_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

    // The held response always shows the live flag state.
    `AFU_ASSERT(a_rsp_flags_live, i_clk, i_rst_n, o_rsp.valid |-> (o_rsp.flags_out[7:4] == r_flags))
    // Accumulator moves only when a request executes.
    `AFU_ASSERT(a_acc_quiet, i_clk, i_rst_n, !w_fire |=> $stable(r_acc))
    // Compare leaves the accumulator alone.
    `AFU_ASSERT(a_cp_keeps_acc, i_clk, i_rst_n, (w_fire && (w_item.command == aluf_pkg::CMD_CP)) |=> $stable(r_acc))
    // Additions always clear N.
    `AFU_ASSERT(a_add_clears_n, i_clk, i_rst_n, (w_fire && ((w_item.command == aluf_pkg::CMD_ADD) || (w_item.command == aluf_pkg::CMD_ADC))) |=> !r_flags.n)
    // Reset restores the accumulator value.
    `AFU_ASSERT_ALWAYS(a_reset_acc, i_clk, !i_rst_n |=> (r_acc == aluf_pkg::ACC_RESET))

endmodule

`default_nettype wire

@@ tb/accumulator_alu_with_flags_unit_tb.sv @@
module accumulator_alu_with_flags_unit_tb;
    import aluf_pkg::*;

    // Command codes past CMD_CCF are undefined and must leave all state alone.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNKNOWN = 5'd17;
    localparam logic [CMD_W-1:0] CMD_LAST_UNKNOWN  = 5'd31;

    localparam int NUM_RANDOM     = 975;
    localparam int REPORT_LIMIT   = 10;
    // Idle time to wait after the last result before closing out.
    localparam int DRAIN_CYCLES   = 8;
    // Longest legal quiet stretch is the receiver hold-off plus a couple of
    // idle bursts and the pipeline depth; give it a wide margin.
    localparam int STALL_LIMIT    = 500;
    localparam int TAIL_ITEMS     = 150;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 40;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] flag_byte;
    } alu_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aluf_req_if req_if ();
    aluf_rsp_if rsp_if ();

    accumulator_alu_with_flags_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Requests still to be offered, and results owed by the block in order.
    t_req_item   pending_cmds[$];
    alu_result_t expected_results[$];

    // Shadow copy of the architectural state.
    logic [DATA_W-1:0] acc_shadow;
    t_flags            flags_shadow;

    int   total_reqs      = 0;
    int   accepted_reqs   = 0;
    int   checked_results = 0;
    int   error_count     = 0;
    int   idle_cycles     = 0;
    int   send_gap        = 0;
    int   recv_gap        = 0;
    int   holdoff_left    = 0;
    logic holdoff_done    = 1'b0;
    logic req_taken       = 1'b0;

    // Run without any idling near the end, and in every third window of
    // 64 requests, so back-to-back traffic gets exercised too.
    logic quiet_phase;
    assign quiet_phase = ((total_reqs - accepted_reqs) < TAIL_ITEMS)
                         || ((accepted_reqs / 64) % 3 == 2);

    // Execute one command against the shadow state; return the response it owes.
    function automatic alu_result_t exec_alu(input logic [CMD_W-1:0] code,
                                             input logic [DATA_W-1:0] opnd);
        logic [DATA_W-1:0] res;
        t_flags            nf;
        logic              keep_acc;
        int                a;
        int                v;
        int                ci;
        int                wide;
        a        = acc_shadow;
        v        = opnd;
        ci       = flags_shadow.c;
        res      = acc_shadow;
        nf       = flags_shadow;
        keep_acc = 1'b0;
        case (code)
            CMD_ADD, CMD_ADC: begin
                if (code == CMD_ADD) ci = 0;
                wide = a + v + ci;
                res  = wide[7:0];
                nf   = {res == 8'h00, 1'b0, ((a & 15) + (v & 15) + ci) > 15, wide > 255};
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                if (code != CMD_SBC) ci = 0;
                wide = a - v - ci;
                res  = wide[7:0];
                nf   = {res == 8'h00, 1'b1, (a & 15) < ((v & 15) + ci), a < (v + ci)};
                // Compare only sets flags; the accumulator comes back untouched.
                if (code == CMD_CP) begin
                    res      = acc_shadow;
                    keep_acc = 1'b1;
                end
            end
            CMD_AND: begin
                res = acc_shadow & opnd;
                nf  = {res == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            CMD_OR: begin
                res = acc_shadow | opnd;
                nf  = {res == 8'h00, 3'b000};
            end
            CMD_XOR: begin
                res = acc_shadow ^ opnd;
                nf  = {res == 8'h00, 3'b000};
            end
            // INC/DEC work on the operand and keep carry.
            CMD_INC: begin
                res      = opnd + 8'h01;
                nf       = {res == 8'h00, 1'b0, opnd[3:0] == 4'hF, flags_shadow.c};
                keep_acc = 1'b1;
            end
            CMD_DEC: begin
                res      = opnd - 8'h01;
                nf       = {res == 8'h00, 1'b1, opnd[3:0] == 4'h0, flags_shadow.c};
                keep_acc = 1'b1;
            end
            CMD_RLCA: begin
                res = {acc_shadow[6:0], acc_shadow[7]};
                nf  = {3'b000, acc_shadow[7]};
            end
            CMD_RRCA: begin
                res = {acc_shadow[0], acc_shadow[7:1]};
                nf  = {3'b000, acc_shadow[0]};
            end
            CMD_RLA: begin
                res = {acc_shadow[6:0], flags_shadow.c};
                nf  = {3'b000, acc_shadow[7]};
            end
            CMD_RRA: begin
                res = {flags_shadow.c, acc_shadow[7:1]};
                nf  = {3'b000, acc_shadow[0]};
            end
            CMD_CPL: begin
                res = ~acc_shadow;
                nf  = {flags_shadow.z, 1'b1, 1'b1, flags_shadow.c};
            end
            CMD_SCF: nf = {flags_shadow.z, 2'b00, 1'b1};
            CMD_CCF: nf = {flags_shadow.z, 2'b00, ~flags_shadow.c};
            default: keep_acc = 1'b1;
        endcase
        if (!keep_acc) acc_shadow = res;
        flags_shadow = nf;
        return {res, nf, 4'h0};
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Request driver: advance on the falling edge, hold a request until taken.
    always @(negedge i_clk) begin : req_driver
        t_req_item nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            // hold the current request
        end else if (send_gap > 0) begin
            send_gap     = send_gap - 1;
            req_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0 && !quiet_phase && $urandom_range(0, 5) == 0) begin
            // drop valid for a burst, its length drawn at random into send_gap
            send_gap     = $urandom_range(0, 3);
            req_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
            nxt                  = pending_cmds.pop_front();
            req_if.valid         <= 1'b1;
            req_if.command       <= nxt.command;
            req_if.operand_value <= nxt.operand_value;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Response sink: random ready bursts plus one long hold-off that backs the
    // pipeline up into the request side.
    always @(negedge i_clk) begin : rsp_sink
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (!holdoff_done && accepted_reqs >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap     = recv_gap - 1;
            rsp_if.ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            recv_gap     = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted request, then check every accepted
    // response against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        alu_result_t want;
        logic        req_fire;
        logic        rsp_fire;
        if (i_rst_n) begin
            req_fire  = req_if.valid && req_if.ready;
            rsp_fire  = rsp_if.valid && rsp_if.ready;
            req_taken <= req_fire;
            if (req_fire) begin
                expected_results.push_back(exec_alu(req_if.command, req_if.operand_value));
                accepted_reqs++;
            end
            if (rsp_fire) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result value=%02h flags=%02h",
                                           rsp_if.result_value, rsp_if.flags_out));
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.result_value !== want.value)
                        report_error($sformatf("result #%0d value: expected %02h, got %02h",
                                               checked_results, want.value,
                                               rsp_if.result_value));
                    if (rsp_if.flags_out !== want.flag_byte)
                        report_error($sformatf("result #%0d flags: expected %02h, got %02h",
                                               checked_results, want.flag_byte,
                                               rsp_if.flags_out));
                end
                checked_results++;
            end
            idle_cycles <= (req_fire || rsp_fire) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no request or result accepted for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_req_item it;
        int        n;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.command       = '0;
        req_if.operand_value = '0;
        rsp_if.ready         = 1'b0;
        acc_shadow           = ACC_RESET;
        flags_shadow         = '0;

        // Directed: carries and half carries out of the reset accumulator,
        // borrows, compare, logic ops, INC/DEC wraps, rotates through carry,
        // complement, carry flag ops and undefined codes.
        pending_cmds.push_back({CMD_ADD,  8'hFF});   // 01+FF wraps to zero
        pending_cmds.push_back({CMD_ADC,  8'h00});   // carry in only
        pending_cmds.push_back({CMD_ADD,  8'h0F});   // nibble carry
        pending_cmds.push_back({CMD_SUB,  8'h10});   // exact zero
        pending_cmds.push_back({CMD_SUB,  8'h01});   // borrow through all bits
        pending_cmds.push_back({CMD_SBC,  8'hFF});   // borrow in plus max operand
        pending_cmds.push_back({CMD_CP,   8'hFF});   // equal, accumulator kept
        pending_cmds.push_back({CMD_CP,   8'h00});
        pending_cmds.push_back({CMD_AND,  8'h00});
        pending_cmds.push_back({CMD_OR,   8'h80});
        pending_cmds.push_back({CMD_XOR,  8'h80});
        pending_cmds.push_back({CMD_OR,   8'hFF});
        pending_cmds.push_back({CMD_INC,  8'hFF});
        pending_cmds.push_back({CMD_INC,  8'h0F});
        pending_cmds.push_back({CMD_DEC,  8'h00});
        pending_cmds.push_back({CMD_DEC,  8'h01});
        pending_cmds.push_back({CMD_RLCA, 8'hA5});
        pending_cmds.push_back({CMD_SCF,  8'hFF});
        pending_cmds.push_back({CMD_RRA,  8'h00});
        pending_cmds.push_back({CMD_RLA,  8'h5A});
        pending_cmds.push_back({CMD_CCF,  8'h00});
        pending_cmds.push_back({CMD_RRCA, 8'hFF});
        pending_cmds.push_back({CMD_CPL,  8'h00});
        pending_cmds.push_back({CMD_FIRST_UNKNOWN, 8'hFF});
        pending_cmds.push_back({CMD_LAST_UNKNOWN,  8'h00});

        // Random: mostly defined commands, a few undefined codes, operands
        // biased toward nibble and byte boundaries.
        for (n = 0; n < NUM_RANDOM; n++) begin
            if ($urandom_range(0, 19) == 0)
                it.command = CMD_W'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
            else
                it.command = CMD_W'($urandom_range(CMD_ADD, CMD_CCF));
            it.operand_value = DATA_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                it.operand_value[3:0] = $urandom_range(0, 1) ? 4'hF : 4'h0;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       it.operand_value = 8'h00;
                    1:       it.operand_value = 8'hFF;
                    2:       it.operand_value = 8'h80;
                    default: it.operand_value = 8'h7F;
                endcase
            end
            pending_cmds.push_back(it);
        end
        total_reqs = pending_cmds.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come back.
        while (accepted_reqs < total_reqs || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
